// File: rtl/core/ansi_escape_strip_normalizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape stripper
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_STRIP_NORMALIZER_DEFINES_SVH
`define ANSI_ESCAPE_STRIP_NORMALIZER_DEFINES_SVH

// Same-cycle implication.
`define AESN_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("aesn: implication check failed");

// Next-cycle implication.
`define AESN_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("aesn: next-cycle check failed");

`endif

// File: rtl/core/aesn_pkg.sv
// ----------------------------------------------------------------------------
// Escape stripper package
// Character constants, the result descriptor and the tab width clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package aesn_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TabWidth   = 4;
   localparam int unsigned MaxRepeat  = 8;

   localparam logic [TabWidth-1:0] TabWidthReset = 4'd4;

   localparam logic [ByteWidth-1:0] ChEsc   = 8'h1B;
   localparam logic [ByteWidth-1:0] ChBel   = 8'h07;
   localparam logic [ByteWidth-1:0] ChLf    = 8'h0A;
   localparam logic [ByteWidth-1:0] ChCr    = 8'h0D;
   localparam logic [ByteWidth-1:0] ChTab   = 8'h09;
   localparam logic [ByteWidth-1:0] ChSpace = 8'h20;
   localparam logic [ByteWidth-1:0] ChLbrk  = 8'h5B;
   localparam logic [ByteWidth-1:0] ChRbrk  = 8'h5D;
   localparam logic [ByteWidth-1:0] ChBslash = 8'h5C;
   localparam logic [ByteWidth-1:0] CsiFinalLo = 8'h40;
   localparam logic [ByteWidth-1:0] CsiFinalHi = 8'h7E;

   // What one accepted byte produces: a byte repeated count times, or nothing.
   typedef struct packed {
      logic                 emit;
      logic [ByteWidth-1:0] data;
      logic [TabWidth-1:0]  count;
   } aesn_emit_type;

   function automatic logic [TabWidth-1:0] tab_clamp(input logic [TabWidth-1:0] w);
      logic [TabWidth-1:0] r;
      r = w;
      if (w == '0) begin
         r = TabWidth'(1);
      end else if (w > TabWidth'(MaxRepeat)) begin
         r = TabWidth'(MaxRepeat);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/aesn_if.sv
// ----------------------------------------------------------------------------
// Escape stripper channels
// Valid/ready channels for raw bytes, cleaned bytes and the tab width write.
// ----------------------------------------------------------------------------
`default_nettype none

interface aesn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface aesn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface aesn_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] tab_width;

   modport source (output valid, output tab_width, input ready);
   modport sink   (input valid, input tab_width, output ready);
endinterface

`default_nettype wire

// File: rtl/core/aesn_scan.sv
// ----------------------------------------------------------------------------
// Escape stripper scanner
// Holds the scan mode and decodes each accepted byte into a result descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module aesn_scan
   import aesn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] in_byte,
   input  logic                 end_of_text,
   input  logic [TabWidth-1:0]  tab_width,
   output aesn_emit_type        emit
);

   localparam logic [2:0] ModeNormal  = 3'd0;
   localparam logic [2:0] ModeEsc     = 3'd1;
   localparam logic [2:0] ModeCsi     = 3'd2;
   localparam logic [2:0] ModeOsc     = 3'd3;
   localparam logic [2:0] ModeOscEsc  = 3'd4;
   localparam logic [2:0] ModeAfterCr = 3'd5;

   logic [2:0]    mode_ff;
   logic [2:0]    mode_in;
   logic [2:0]    mode_next;
   logic [2:0]    norm_mode;
   aesn_emit_type norm_emit;

   // Normal text handling, also used for a byte after CR that is not LF.
   always_comb begin
      norm_mode = ModeNormal;
      norm_emit = '{emit: 1'b1, data: in_byte, count: TabWidth'(1)};
      if (in_byte == ChEsc) begin
         norm_mode      = ModeEsc;
         norm_emit.emit = 1'b0;
      end else if (in_byte == ChCr) begin
         norm_mode      = ModeAfterCr;
         norm_emit.data = ChLf;
      end else if (in_byte == ChTab) begin
         norm_emit.data  = ChSpace;
         norm_emit.count = tab_clamp(tab_width);
      end else if (in_byte < ChSpace && in_byte != ChLf) begin
         norm_emit.emit = 1'b0;
      end
   end

   always_comb begin
      mode_next = mode_ff;
      emit      = '{emit: 1'b0, data: in_byte, count: TabWidth'(1)};
      unique case (mode_ff)
         ModeEsc: begin
            if (in_byte == ChLbrk) begin
               mode_next = ModeCsi;
            end else if (in_byte == ChRbrk) begin
               mode_next = ModeOsc;
            end else begin
               mode_next = ModeNormal;
            end
         end
         ModeCsi: begin
            if (in_byte >= CsiFinalLo && in_byte <= CsiFinalHi) begin
               mode_next = ModeNormal;
            end
         end
         ModeOsc: begin
            if (in_byte == ChBel) begin
               mode_next = ModeNormal;
            end else if (in_byte == ChEsc) begin
               mode_next = ModeOscEsc;
            end
         end
         ModeOscEsc: begin
            if (in_byte == ChBslash || in_byte == ChBel) begin
               mode_next = ModeNormal;
            end else if (in_byte == ChEsc) begin
               mode_next = ModeOscEsc;
            end else begin
               mode_next = ModeOsc;
            end
         end
         ModeAfterCr: begin
            if (in_byte == ChLf) begin
               mode_next = ModeNormal;
            end else begin
               mode_next = norm_mode;
               emit      = norm_emit;
            end
         end
         default: begin
            mode_next = norm_mode;
            emit      = norm_emit;
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         mode_in = end_of_text ? ModeNormal : mode_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeNormal;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ansi_escape_strip_normalizer.sv
// ----------------------------------------------------------------------------
// ANSI escape stripper and text normalizer
// Removes escape sequences, folds CR and CRLF to LF, expands tabs, drops
// other control bytes.
//
//   channel  | dir | payload                  | handshake
//   ---------+-----+--------------------------+-------------
//   req_chan | in  | in_byte, end_of_text     | valid/ready
//   rsp_chan | out | out_byte, run_last       | valid/ready
//   csr_chan | in  | tab_width                | valid/ready
//
// One raw byte is accepted per cycle while the output register is free or
// frees. Each byte is decoded in the cycle it is accepted and lands in a
// single output register; a tab repeats a space there tab_width times, clamped
// to 1..8, during which the input waits. A byte that yields no output only
// updates the scan mode. Reset is synchronous; the tab width returns to 4.
// A stall on rsp_chan holds the output register and stops intake once full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ansi_escape_strip_normalizer_defines.svh"

module ansi_escape_strip_normalizer
   import aesn_pkg::*;
#(
   parameter logic [TabWidth-1:0] TAB_WIDTH_RESET = TabWidthReset
)
(
   input  logic              clock,
   input  logic              reset,
   aesn_req_if.sink          req_chan,
   aesn_rsp_if.source        rsp_chan,
   aesn_csr_if.sink          csr_chan
);

   logic [TabWidth-1:0]  tab_width_ff;
   logic [TabWidth-1:0]  tab_width_in;
   logic                 pend_valid_ff;
   logic                 pend_valid_in;
   logic [ByteWidth-1:0] pend_byte_ff;
   logic [ByteWidth-1:0] pend_byte_in;
   logic [TabWidth-1:0]  pend_count_ff;
   logic [TabWidth-1:0]  pend_count_in;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 pend_last;
   aesn_emit_type        emit;

   assign pend_last = (pend_count_ff == TabWidth'(1));
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign req_fire  = req_chan.valid && req_chan.ready;

   // Input is taken when the output register is free or frees this cycle.
   assign req_chan.ready = !pend_valid_ff || (rsp_chan.ready && pend_last);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid    = pend_valid_ff;
   assign rsp_chan.out_byte = pend_byte_ff;
   assign rsp_chan.run_last = pend_last;

   aesn_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .in_byte     (req_chan.in_byte),
      .end_of_text (req_chan.end_of_text),
      .tab_width   (tab_width_ff),
      .emit        (emit)
   );

   always_comb begin
      tab_width_in = tab_width_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         tab_width_in = csr_chan.tab_width;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_count_in = pend_count_ff;
      if (rsp_fire) begin
         pend_count_in = pend_count_ff - TabWidth'(1);
         if (pend_last) begin
            pend_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         pend_valid_in = emit.emit;
         pend_byte_in  = emit.data;
         pend_count_in = emit.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff  <= TAB_WIDTH_RESET;
         pend_valid_ff <= 1'b0;
      end else begin
         tab_width_ff  <= tab_width_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_byte_ff  <= pend_byte_in;
      pend_count_ff <= pend_count_in;
   end

   `AESN_ASSERT_IMPLY(a_count_nonzero, clock, reset, pend_valid_ff, pend_count_ff != '0)
   `AESN_ASSERT_IMPLY(a_count_bounded, clock, reset, pend_valid_ff,
                      pend_count_ff <= TabWidth'(MaxRepeat))
   `AESN_ASSERT_IMPLY(a_no_overwrite, clock, reset, req_fire && pend_valid_ff,
                      rsp_fire && pend_last)
   `AESN_ASSERT_NEXT(a_repeat_holds, clock, reset, rsp_fire && !pend_last,
                     pend_valid_ff && $stable(pend_byte_ff))

endmodule

`default_nettype wire
